// ===== hdl/par_pkg.sv =====
// Shared types, constants and the coefficient table of the resampler.
package par_pkg;
  localparam int TAPS = 10;
  localparam int ORDER = 6;
  localparam int FRAC_BITS = 14;
  localparam int STEP_W = 36;
  localparam int PHASE_W = 37;
  localparam int LIMIT_W = 7;
  localparam int OUT_W = 32;
  localparam int IN_W = 16;
  localparam int COEF_W = 16;
  localparam int MAX_OUT = 64;
  localparam int ACC_W = 64;

  localparam logic [0:0] ACT_PUSH = 1'b0;
  localparam logic [0:0] ACT_CLEAR = 1'b1;

  localparam logic [0:0] REG_STEP = 1'b0;
  localparam logic [0:0] REG_LIMIT = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } mul_req_t;

  function automatic coef_t coef_at(input logic [2:0] k, input logic [3:0] i);
    coef_t c;
    c = '0;
    case ({k, i})
      {3'd0, 4'd4}: c = 16'sd16384;
      {3'd1, 4'd0}: c = 16'sd133;   {3'd1, 4'd1}: c = -16'sd894;
      {3'd1, 4'd2}: c = 16'sd3513;  {3'd1, 4'd3}: c = -16'sd12473;
      {3'd1, 4'd4}: c = -16'sd2217; {3'd1, 4'd5}: c = 16'sd16425;
      {3'd1, 4'd6}: c = -16'sd6285; {3'd1, 4'd7}: c = 16'sd2373;
      {3'd1, 4'd8}: c = -16'sd683;  {3'd1, 4'd9}: c = 16'sd108;
      {3'd2, 4'd0}: c = -16'sd37;   {3'd2, 4'd1}: c = 16'sd339;
      {3'd2, 4'd2}: c = -16'sd2021; {3'd2, 4'd3}: c = 16'sd13844;
      {3'd2, 4'd4}: c = -16'sd24348;{3'd2, 4'd5}: c = 16'sd14142;
      {3'd2, 4'd6}: c = -16'sd2377; {3'd2, 4'd7}: c = 16'sd560;
      {3'd2, 4'd8}: c = -16'sd116;  {3'd2, 4'd9}: c = 16'sd14;
      {3'd3, 4'd0}: c = -16'sd236;  {3'd3, 4'd1}: c = 16'sd1496;
      {3'd3, 4'd2}: c = -16'sd4962; {3'd3, 4'd3}: c = 16'sd5793;
      {3'd3, 4'd4}: c = 16'sd2348;  {3'd3, 4'd5}: c = -16'sd10351;
      {3'd3, 4'd6}: c = 16'sd8789;  {3'd3, 4'd7}: c = -16'sd3887;
      {3'd3, 4'd8}: c = 16'sd1211;  {3'd3, 4'd9}: c = -16'sd201;
      {3'd4, 4'd0}: c = 16'sd162;   {3'd4, 4'd1}: c = -16'sd1118;
      {3'd4, 4'd2}: c = 16'sd4309;  {3'd4, 4'd3}: c = -16'sd9509;
      {3'd4, 4'd4}: c = 16'sd11721; {3'd4, 4'd5}: c = -16'sd7720;
      {3'd4, 4'd6}: c = 16'sd2218;  {3'd4, 4'd7}: c = 16'sd115;
      {3'd4, 4'd8}: c = -16'sd236;  {3'd4, 4'd9}: c = 16'sd58;
      {3'd5, 4'd0}: c = -16'sd21;   {3'd5, 4'd1}: c = 16'sd176;
      {3'd5, 4'd2}: c = -16'sd839;  {3'd5, 4'd3}: c = 16'sd2345;
      {3'd5, 4'd4}: c = -16'sd3888; {3'd5, 4'd5}: c = 16'sd3888;
      {3'd5, 4'd6}: c = -16'sd2345; {3'd5, 4'd7}: c = 16'sd839;
      {3'd5, 4'd8}: c = -16'sd176;  {3'd5, 4'd9}: c = 16'sd21;
      default: c = '0;
    endcase
    return c;
  endfunction
endpackage

// ===== hdl/par_if.sv =====
// Valid/ready channel interfaces for samples, results and configuration.
interface par_in_if;
  logic valid;
  logic ready;
  logic [0:0] action;
  logic signed [15:0] sample_in;
  modport source (output valid, output action, output sample_in, input ready);
  modport sink (input valid, input action, input sample_in, output ready);
endinterface

interface par_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample_out;
  logic last;
  modport source (output valid, output sample_out, output last, input ready);
  modport sink (input valid, input sample_out, input last, output ready);
endinterface

interface par_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [35:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/par_sermul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, 64-bit product.
module par_sermul (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  par_pkg::mul_req_t req,
  output logic busy,
  output logic done,
  output logic signed [par_pkg::ACC_W-1:0] prod
);
  import par_pkg::*;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic signed [ACC_W-1:0] mcand_r, mcand_nxt;
  logic [ACC_W-1:0] mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  // two's complement serial multiply mod 2^64: add shifted multiplicand per bit
  always_comb begin
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mcand_nxt = req.a;
      mplier_nxt = req.b;
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ACC_W - 1) || mplier_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;
endmodule

// ===== hdl/polynomial_audio_resampler_top.sv =====
// Top level of the polynomial sample-rate converter.
//   channel | dir | payload
//   in_     | in  | action, sample_in
//   out_    | out | sample_out, last
//   cfg_    | in  | index (0 phase_step, 1 output_limit), data
// One item at a time. Each output: 60 dot-product terms and 6 Horner steps, each
// through one bit-serial multiplier, which sets the pace; each push also passes
// through a check step.
// Reset is synchronous: history, phase and primed clear at once, registers reload.
// A stalled out_ beat holds the engine in its emit step once the next output is
// ready; in_ is taken only when the block is idle.
module polynomial_audio_resampler_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  par_in_if.sink in_ch,
  par_out_if.source out_ch,
  par_cfg_if.sink cfg_ch
);
  import par_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DOT = 3'd2;
  localparam logic [2:0] S_HORN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_WAITH = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic signed [SAMPLE_WIDTH-1:0] hist_r [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_nxt [TAPS];
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic primed_r, primed_nxt;
  logic [STEP_W-1:0] step_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [2:0] k_r, k_nxt;
  logic [3:0] i_r, i_nxt;
  logic [LIMIT_W-1:0] n_r, n_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, c_r, c_nxt;
  logic signed [OUT_W-1:0] res_r, res_nxt;
  logic last_r, last_nxt, ov_r, ov_nxt;

  logic mstart, mbusy, mdone;
  mul_req_t mreq;
  logic signed [ACC_W-1:0] mprod;
  logic [LIMIT_W-1:0] cap;
  logic [FRAC_BITS-1:0] mu;
  logic more;
  logic [PHASE_W-1:0] ph_adv;
  logic signed [ACC_W-1:0] hsum;
  logic [SAMPLE_WIDTH-1:0] smp_raw;

  par_sermul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .req(mreq),
    .busy(mbusy), .done(mdone), .prod(mprod));

  // raw field bits, zero-extended or cut to the sample width
  assign smp_raw = SAMPLE_WIDTH'($unsigned(in_ch.sample_in));
  assign cap = (limit_r > LIMIT_W'(MAX_OUT)) ? LIMIT_W'(MAX_OUT) : limit_r;
  assign mu = phase_r[31:32-FRAC_BITS];
  assign ph_adv = phase_r + PHASE_W'(step_r);
  assign more = (ph_adv < (PHASE_W'(1) << 32)) && ((n_r + 1'b1) < cap);
  assign hsum = (mprod >>> FRAC_BITS) + c_r;

  assign in_ch.ready = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.sample_out = res_r;
  assign out_ch.last = last_r;

  always_comb begin
    st_nxt = st_r;
    hist_nxt = hist_r;
    phase_nxt = phase_r;
    primed_nxt = primed_r;
    k_nxt = k_r;
    i_nxt = i_r;
    n_nxt = n_r;
    acc_nxt = acc_r;
    c_nxt = c_r;
    res_nxt = res_r;
    last_nxt = last_r;
    ov_nxt = ov_r;
    mstart = 1'b0;
    mreq.a = ACC_W'(coef_at(k_r, i_r));
    mreq.b = ACC_W'(hist_r[i_r]);
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == ACT_CLEAR) begin
            for (int t = 0; t < TAPS; t++) hist_nxt[t] = '0;
            phase_nxt = '0;
            primed_nxt = 1'b0;
          end else begin
            for (int t = 0; t < TAPS - 1; t++)
              hist_nxt[t] = primed_r ? hist_r[t+1] : $signed(smp_raw);
            hist_nxt[TAPS-1] = $signed(smp_raw);
            primed_nxt = 1'b1;
            n_nxt = '0;
            st_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (phase_r < (PHASE_W'(1) << 32) && cap != '0) begin
          k_nxt = 3'(ORDER - 1);
          i_nxt = '0;
          acc_nxt = '0;
          c_nxt = '0;
          st_nxt = S_DOT;
        end else begin
          if (phase_r >= (PHASE_W'(1) << 32)) phase_nxt = phase_r - (PHASE_W'(1) << 32);
          st_nxt = S_IDLE;
        end
      end
      S_DOT: begin
        if (!mbusy && !mdone && !mstart) begin
          mstart = 1'b1;
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mdone) begin
          c_nxt = c_r + mprod;
          if (i_r == 4'(TAPS - 1)) begin
            mreq.a = acc_r;
            mreq.b = ACC_W'(mu);
            mstart = 1'b1;
            st_nxt = S_WAITH;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_DOT;
          end
        end
      end
      S_WAITH: begin
        if (mdone) begin
          acc_nxt = hsum;
          c_nxt = '0;
          i_nxt = '0;
          if (k_r == '0) begin
            st_nxt = S_EMIT;
          end else begin
            k_nxt = k_r - 1'b1;
            st_nxt = S_DOT;
          end
        end
      end
      S_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          res_nxt = OUT_W'(acc_r >>> FRAC_BITS);
          last_nxt = !more;
          n_nxt = n_r + 1'b1;
          phase_nxt = ph_adv;
          if (more) begin
            k_nxt = 3'(ORDER - 1);
            acc_nxt = '0;
            c_nxt = '0;
            st_nxt = S_DOT;
          end else begin
            if (ph_adv >= (PHASE_W'(1) << 32)) phase_nxt = ph_adv - (PHASE_W'(1) << 32);
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int t = 0; t < TAPS; t++) hist_r[t] <= '0;
      phase_r <= '0;
      primed_r <= 1'b0;
      step_r <= STEP_W'(64'h1_0000_0000);
      limit_r <= LIMIT_W'(MAX_OUT);
      ov_r <= 1'b0;
      n_r <= '0;
      k_r <= '0;
      i_r <= '0;
    end else begin
      st_r <= st_nxt;
      hist_r <= hist_nxt;
      phase_r <= phase_nxt;
      primed_r <= primed_nxt;
      ov_r <= ov_nxt;
      n_r <= n_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_STEP) step_r <= cfg_ch.data;
        else limit_r <= cfg_ch.data[LIMIT_W-1:0];
      end
    end
    acc_r <= acc_nxt;
    c_r <= c_nxt;
    res_r <= res_nxt;
    last_r <= last_nxt;
  end
endmodule

// ===== tb/tb_polynomial_audio_resampler_top.sv =====
// Self-checking testbench for the polynomial sample-rate converter top level.
module tb_polynomial_audio_resampler_top;
  import par_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 300;
  localparam longint unsigned UNIT_PHASE = 64'd1 << 32;
  localparam longint unsigned PH_MASK = (64'd1 << PHASE_W) - 1;
  localparam longint unsigned STEP_MAX = (64'd1 << STEP_W) - 1;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic last;
  } interp_beat_t;

  typedef struct {
    bit is_cfg;
    longint unsigned step;
    int limit;
    logic [0:0] action;
    logic signed [IN_W-1:0] sample;
    bit known;
    int known_value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  par_in_if in_ch();
  par_out_if out_ch();
  par_cfg_if cfg_ch();

  polynomial_audio_resampler_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Q14 interpolation matrix, row k is the coefficient of mu^k
  int farrow_coef [0:ORDER-1][0:TAPS-1] = '{
    '{0, 0, 0, 0, 16384, 0, 0, 0, 0, 0},
    '{133, -894, 3513, -12473, -2217, 16425, -6285, 2373, -683, 108},
    '{-37, 339, -2021, 13844, -24348, 14142, -2377, 560, -116, 14},
    '{-236, 1496, -4962, 5793, 2348, -10351, 8789, -3887, 1211, -201},
    '{162, -1118, 4309, -9509, 11721, -7720, 2218, 115, -236, 58},
    '{-21, 176, -839, 2345, -3888, 3888, -2345, 839, -176, 21}
  };

  int sample_hist [0:TAPS-1];
  longint unsigned phase_now;
  bit hist_primed;
  longint unsigned step_reg;
  int limit_reg;

  interp_beat_t pending_out[$];
  stim_row_t rows[$];
  int errors;
  int idle_cycles;
  int in_gap_pct;
  int out_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [OUT_W-1:0] horner_eval(longint unsigned mu);
    longint acc;
    longint dot;
    acc = 0;
    for (int k = ORDER - 1; k >= 0; k--) begin
      dot = 0;
      for (int i = 0; i < TAPS; i++) dot += longint'(farrow_coef[k][i]) * sample_hist[i];
      acc = ((acc * longint'(mu)) >>> FRAC_BITS) + dot;
    end
    acc = acc >>> FRAC_BITS;
    return acc[OUT_W-1:0];
  endfunction

  function automatic void predict_item(logic [0:0] act, logic signed [IN_W-1:0] smp);
    int n;
    int cap;
    interp_beat_t b;
    n = 0;
    if (act == ACT_CLEAR) begin
      foreach (sample_hist[i]) sample_hist[i] = 0;
      phase_now = 0;
      hist_primed = 0;
      return;
    end
    if (!hist_primed) begin
      foreach (sample_hist[i]) sample_hist[i] = int'(smp);
      hist_primed = 1;
    end else begin
      for (int i = 0; i < TAPS - 1; i++) sample_hist[i] = sample_hist[i+1];
      sample_hist[TAPS-1] = int'(smp);
    end
    cap = (limit_reg > MAX_OUT) ? MAX_OUT : limit_reg;
    while (phase_now < UNIT_PHASE && n < cap) begin
      b.value = horner_eval((phase_now >> (32 - FRAC_BITS)) & ((64'd1 << FRAC_BITS) - 1));
      b.last = 1'b0;
      pending_out.push_back(b);
      n++;
      phase_now = (phase_now + step_reg) & PH_MASK;
    end
    // if the cap stops the loop below one unit, the phase is left unwrapped
    if (phase_now >= UNIT_PHASE) phase_now -= UNIT_PHASE;
    if (n > 0) pending_out[$].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected beat sample_out=%0d last=%0b", $time,
                 out_ch.sample_out, out_ch.last);
        errors++;
      end else begin
        interp_beat_t e;
        e = pending_out.pop_front();
        if (out_ch.sample_out !== e.value) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, e.value,
                   out_ch.sample_out);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid is left high after a beat so the next call can keep it up
  task automatic send_item(logic [0:0] act, logic signed [IN_W-1:0] smp);
    if ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_gap_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sample_in <= smp;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(act, smp);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(longint unsigned step, int limit);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_STEP;
    cfg_ch.data <= step[STEP_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_LIMIT;
    cfg_ch.data <= STEP_W'(limit);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    step_reg = step & STEP_MAX;
    limit_reg = limit & 8'h7F;
  endtask

  task automatic add_item(logic [0:0] act, logic signed [IN_W-1:0] smp, bit known = 0,
                          int kv = 0);
    rows.push_back('{0, 0, 0, act, smp, known, kv});
  endtask

  task automatic add_cfg(longint unsigned step, int limit);
    rows.push_back('{1, step, limit, ACT_PUSH, '0, 0, 0});
  endtask

  initial begin
    stim_row_t r;
    longint unsigned st;
    int lim;
    errors = 0;
    idle_cycles = 0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.sample_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    foreach (sample_hist[i]) sample_hist[i] = 0;
    phase_now = 0;
    hist_primed = 0;
    step_reg = UNIT_PHASE;
    limit_reg = MAX_OUT;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults give one beat per push at mu = 0
    add_item(ACT_PUSH, 16'sd0, 1, 0);
    add_item(ACT_PUSH, 16'sd32767);
    add_item(ACT_PUSH, -16'sd32768);
    add_item(ACT_CLEAR, 16'sd0);
    add_item(ACT_PUSH, -16'sd32768, 1, -32768);
    add_item(ACT_CLEAR, 16'sd0);
    add_item(ACT_PUSH, 16'sd32767, 1, 32767);
    add_item(ACT_PUSH, 16'sd12345);
    add_cfg(64'h8000_0000, MAX_OUT);
    add_item(ACT_PUSH, -16'sd1);
    add_item(ACT_PUSH, 16'sd1);
    add_cfg(64'h4000_0000, 1);          // cap hit, phase left unwrapped
    add_item(ACT_PUSH, 16'sd20000);
    add_item(ACT_PUSH, -16'sd20000);
    add_cfg(0, 3);                      // zero step: all beats at one phase
    add_item(ACT_PUSH, 16'sd7);
    add_cfg(STEP_MAX, MAX_OUT);         // huge step, later pushes skip
    add_item(ACT_PUSH, 16'sd300);
    add_item(ACT_PUSH, -16'sd300);
    add_item(ACT_PUSH, 16'sd5);
    add_cfg(1, 2);
    add_item(ACT_CLEAR, 16'sd0);
    add_item(ACT_PUSH, -16'sd12345);
    add_item(ACT_PUSH, 16'sd4096);
    add_cfg(UNIT_PHASE, MAX_OUT);

    foreach (rows[n]) begin
      r = rows[n];
      if (r.is_cfg) begin
        drain();
        write_regs(r.step, r.limit);
      end else begin
        send_item(r.action, r.sample);
        if (r.known) begin
          void'(pending_out.pop_back());
          pending_out.push_back('{r.known_value, 1'b1});
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_gap_pct = 0; out_stall_pct = 0; end
        1: begin in_gap_pct = 62; out_stall_pct = 0; end
        2: begin in_gap_pct = 0; out_stall_pct = 62; end
        default: begin in_gap_pct = 18; out_stall_pct = 18; end
      endcase
      for (int n = 0; n < 25; n++) begin
        if (n % 12 == 0) begin
          case ($urandom_range(4))
            0: st = UNIT_PHASE;
            1: st = 64'h8000_0000;
            2: st = 64'hC000_0000;
            3: st = 64'h1_4000_0000;
            default: st = {$urandom_range(1, 7), $urandom()} + 64'h8000_0000;
          endcase
          lim = ($urandom_range(3) == 0) ? MAX_OUT : $urandom_range(1, 4);
          drain();
          write_regs(st, lim);
        end
        if ($urandom_range(11) == 0) send_item(ACT_CLEAR, 16'($urandom()));
        else if ($urandom_range(9) == 0)
          send_item(ACT_PUSH, $urandom_range(1) ? 16'sh7FFF : 16'sh8000);
        else send_item(ACT_PUSH, 16'($urandom()));
      end
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // leftover expectations are caught by the watchdog: drain only returns once the queue is empty
endmodule

// ===== sim.f =====
hdl/par_pkg.sv
hdl/par_if.sv
hdl/par_sermul.sv
hdl/polynomial_audio_resampler_top.sv
tb/tb_polynomial_audio_resampler_top.sv
